// ===== design/trru_pkg.sv =====
`default_nettype none
package trru_pkg;

	localparam int unsigned FactorW = 32;
	localparam int unsigned RadiusW = 63;
	localparam int unsigned ValueW  = 64;

	// fixed grow factor used when the predicted change is zero: 1.2 in Q8.24
	localparam logic [FactorW-1:0] ForcedGrowQ24 = 32'd20132659;
	localparam logic [RadiusW-1:0] RadiusOne     = 63'd281474976710656;
	localparam logic [ValueW-1:0]  SignBit       = 64'h8000_0000_0000_0000;
	localparam logic [ValueW-1:0]  MaxPos        = 64'h7FFF_FFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		CFG_GOOD_LOW  = 3'd0,
		CFG_GOOD_HIGH = 3'd1,
		CFG_GROW      = 3'd2,
		CFG_OK_LOW    = 3'd3,
		CFG_OK_HIGH   = 3'd4,
		CFG_SHRINK    = 3'd5,
		CFG_RAD_MIN   = 3'd6,
		CFG_RAD_MAX   = 3'd7
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_DEC,
		ST_DIV,
		ST_CMP,
		ST_M_LO,
		ST_M_HI,
		ST_M_FIN,
		ST_PROD,
		ST_SQRT,
		ST_CLAMP,
		ST_FIN
	} st_t;

	typedef enum logic [2:0] {
		OP_FORCE,
		OP_GROW,
		OP_SHR_A,
		OP_SHR_B,
		OP_SHR_P
	} op_t;

	typedef struct packed {
		logic signed [ValueW-1:0] new_residual;
		logic signed [ValueW-1:0] base_residual;
		logic signed [ValueW-1:0] predicted_residual;
		logic                     took_full_step;
		logic [RadiusW-1:0]       full_step_norm;
	} in_t;

	typedef struct packed {
		logic [RadiusW-1:0]       new_radius;
		logic                     reject_step;
		logic                     update_ok;
		logic signed [ValueW-1:0] change_ratio;
		logic                     ratio_valid;
	} out_t;

endpackage
`default_nettype wire

// ===== design/trust_region_radius_update_top.sv =====
// A zero predicted change with the radius at its maximum goes straight to the result;
// otherwise a forced grow, or the ratio path (divide, compare) with an optional grow or
// shrink, where a full-step shrink also forms a product and takes its square root.
// Transactions: one at a time, the next accepted only after the result; the
// 112-step divider and the 64-step square root dominate, and a held result stalls the next.
// Reset (arst_n low): registers take their documented defaults, radius is 1.0.
`default_nettype none
module trust_region_radius_update_top (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire trru_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output trru_pkg::out_t      out_data,
	input  wire logic           cfg_we,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [62:0]    cfg_data
);

	trru_pkg::st_t state_q, state_d;
	trru_pkg::op_t op_q;
	trru_pkg::in_t inp_q;
	trru_pkg::out_t out_q;
	logic out_valid_q;

	logic [31:0] good_lo_q, good_hi_q, grow_q, ok_lo_q, ok_hi_q, shrink_q;
	logic [62:0] rad_min_q, rad_max_q, radius_q;

	logic [63:0] a_mag_q, p_mag_q;
	logic a_neg_q, p_neg_q;
	logic [63:0] numsh_q, rem_q, quo_q;
	logic [6:0] cnt_q;
	logic [63:0] ratio_q;
	logic ratio_valid_q, ok_q;
	logic [63:0] d_q;
	logic [63:0] mop_d_q;
	logic [31:0] mop_f_q;
	logic [63:0] mlo_q, mhi_q, mp_q, ta_q, tb_q;
	logic [127:0] acc_q;
	logic [66:0] srem_q;
	logic [63:0] root_q;

	// exact differences
	logic signed [64:0] a_diff, p_diff;
	assign a_diff = {inp_q.new_residual[63], inp_q.new_residual}
		- {inp_q.base_residual[63], inp_q.base_residual};
	assign p_diff = {inp_q.predicted_residual[63], inp_q.predicted_residual}
		- {inp_q.base_residual[63], inp_q.base_residual};

	// shared 32x32 multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [1:0] pk;
	assign pk = cnt_q[1:0];
	always_comb begin
		mul_a = mop_d_q[31:0];
		mul_b = mop_f_q;
		if (state_q == trru_pkg::ST_M_HI) begin
			mul_a = mop_d_q[63:32];
		end else if (state_q == trru_pkg::ST_PROD) begin
			mul_a = pk[1] ? ta_q[63:32] : ta_q[31:0];
			mul_b = pk[0] ? tb_q[63:32] : tb_q[31:0];
		end
	end
	assign mul_p = 64'(mul_a) * 64'(mul_b);

	// combine Q8.24 partial products with saturation
	logic [63:0] mul_res;
	assign mul_res = (mhi_q[63:55] != '0) ? '1 : ((mhi_q << 8) + (mlo_q >> 24));
	logic res_gt_max;
	assign res_gt_max = mul_res > {1'b0, rad_max_q};

	// one restoring division step
	logic [63:0] div_sh, div_rem, quo_sh;
	logic div_ge;
	assign div_sh  = {rem_q[62:0], numsh_q[63]};
	assign div_ge  = rem_q[63] || (div_sh >= p_mag_q);
	assign div_rem = div_ge ? div_sh - p_mag_q : div_sh;
	always_comb begin
		quo_sh = quo_q;
		if (quo_q < trru_pkg::SignBit) begin
			quo_sh = {quo_q[62:0], div_ge};
			if (quo_sh > trru_pkg::SignBit) quo_sh = trru_pkg::SignBit;
		end
	end

	// ratio and band compares
	logic r_neg, gt_lg, lt_ug, lt_lo, gt_uo, a_below, do_grow, do_shrink;
	logic [63:0] r_mag;
	assign r_neg = (a_neg_q != p_neg_q) && (quo_q != '0);
	assign r_mag = (!r_neg && quo_q > trru_pkg::MaxPos) ? trru_pkg::MaxPos : quo_q;
	assign gt_lg = !r_neg && (r_mag > {8'd0, good_lo_q, 24'd0});
	assign lt_ug = r_neg || (r_mag < {8'd0, good_hi_q, 24'd0});
	assign lt_lo = r_neg || (r_mag < {8'd0, ok_lo_q, 24'd0});
	assign gt_uo = !r_neg && (r_mag > {8'd0, ok_hi_q, 24'd0});
	assign a_below = a_neg_q && (a_mag_q != '0);
	assign do_grow = gt_lg && a_below && lt_ug;
	assign do_shrink = !do_grow && (lt_lo || gt_uo);

	// partial product accumulate for the 64x64 product
	logic [1:0] pkp;
	logic [127:0] pp_sh;
	assign pkp = 2'(cnt_q - 7'd1);
	always_comb begin
		unique case (pkp)
			2'd0: pp_sh = {64'd0, mp_q};
			2'd1, 2'd2: pp_sh = {32'd0, mp_q, 32'd0};
			default: pp_sh = {mp_q, 64'd0};
		endcase
	end

	// one square-root digit
	logic [66:0] sq_sh, sq_trial;
	logic sq_ge;
	assign sq_sh    = {srem_q[64:0], acc_q[127:126]};
	assign sq_trial = {1'b0, root_q, 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;

	logic fin_go;
	assign fin_go = !out_valid_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			trru_pkg::ST_IDLE: if (in_valid) state_d = trru_pkg::ST_DIFF;
			trru_pkg::ST_DIFF: state_d = trru_pkg::ST_DEC;
			trru_pkg::ST_DEC: begin
				if (p_mag_q != '0) state_d = trru_pkg::ST_DIV;
				else if (d_q >= {1'b0, rad_max_q}) state_d = trru_pkg::ST_FIN;
				else state_d = trru_pkg::ST_M_LO;
			end
			trru_pkg::ST_DIV: if (cnt_q == 7'd111) state_d = trru_pkg::ST_CMP;
			trru_pkg::ST_CMP: begin
				if ((do_grow && !inp_q.took_full_step) || do_shrink)
					state_d = trru_pkg::ST_M_LO;
				else
					state_d = trru_pkg::ST_FIN;
			end
			trru_pkg::ST_M_LO: state_d = trru_pkg::ST_M_HI;
			trru_pkg::ST_M_HI: state_d = trru_pkg::ST_M_FIN;
			trru_pkg::ST_M_FIN: begin
				unique case (op_q)
					trru_pkg::OP_SHR_A: state_d = trru_pkg::ST_M_LO;
					trru_pkg::OP_SHR_B: state_d = trru_pkg::ST_PROD;
					trru_pkg::OP_SHR_P: state_d = trru_pkg::ST_CLAMP;
					default: state_d = trru_pkg::ST_FIN;
				endcase
			end
			trru_pkg::ST_PROD: if (cnt_q == 7'd4) state_d = trru_pkg::ST_SQRT;
			trru_pkg::ST_SQRT: if (cnt_q == 7'd63) state_d = trru_pkg::ST_CLAMP;
			trru_pkg::ST_CLAMP: state_d = trru_pkg::ST_FIN;
			trru_pkg::ST_FIN: if (fin_go) state_d = trru_pkg::ST_IDLE;
			default: state_d = trru_pkg::ST_IDLE;
		endcase
	end

	assign in_ready  = (state_q == trru_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// control state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= trru_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			radius_q    <= trru_pkg::RadiusOne;
			good_lo_q   <= 32'd12582912;
			good_hi_q   <= 32'd23488102;
			grow_q      <= 32'd25165824;
			ok_lo_q     <= 32'd5872026;
			ok_hi_q     <= 32'd83886080;
			shrink_q    <= 32'd4194304;
			rad_min_q   <= 63'd281;
			rad_max_q   <= 63'd2814749767106560000;
		end else begin
			state_q <= state_d;
			if (state_q == trru_pkg::ST_FIN && fin_go) begin
				out_valid_q <= 1'b1;
				radius_q    <= d_q[63] ? trru_pkg::MaxPos[62:0] : d_q[62:0];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (trru_pkg::cfg_idx_t'(cfg_index))
					trru_pkg::CFG_GOOD_LOW:  good_lo_q <= cfg_data[31:0];
					trru_pkg::CFG_GOOD_HIGH: good_hi_q <= cfg_data[31:0];
					trru_pkg::CFG_GROW:      grow_q    <= cfg_data[31:0];
					trru_pkg::CFG_OK_LOW:    ok_lo_q   <= cfg_data[31:0];
					trru_pkg::CFG_OK_HIGH:   ok_hi_q   <= cfg_data[31:0];
					trru_pkg::CFG_SHRINK:    shrink_q  <= cfg_data[31:0];
					trru_pkg::CFG_RAD_MIN:   rad_min_q <= cfg_data;
					trru_pkg::CFG_RAD_MAX:   rad_max_q <= cfg_data;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			trru_pkg::ST_IDLE: begin
				if (in_valid) inp_q <= in_data;
			end
			trru_pkg::ST_DIFF: begin
				a_neg_q <= a_diff[64];
				p_neg_q <= p_diff[64];
				a_mag_q <= a_diff[64] ? 64'(-a_diff) : a_diff[63:0];
				p_mag_q <= p_diff[64] ? 64'(-p_diff) : p_diff[63:0];
				d_q     <= {1'b0, radius_q};
				ok_q    <= 1'b1;
				ratio_q <= '0;
				ratio_valid_q <= 1'b0;
			end
			trru_pkg::ST_DEC: begin
				if (p_mag_q != '0) begin
					numsh_q <= a_mag_q;
					rem_q   <= '0;
					quo_q   <= '0;
					cnt_q   <= '0;
				end else if (d_q >= {1'b0, rad_max_q}) begin
					ok_q <= 1'b0;
				end else begin
					mop_d_q <= d_q;
					mop_f_q <= trru_pkg::ForcedGrowQ24;
					op_q    <= trru_pkg::OP_FORCE;
				end
			end
			trru_pkg::ST_DIV: begin
				numsh_q <= numsh_q << 1;
				rem_q   <= div_rem;
				quo_q   <= quo_sh;
				cnt_q   <= cnt_q + 7'd1;
			end
			trru_pkg::ST_CMP: begin
				ratio_q       <= r_neg ? 64'(-r_mag) : r_mag;
				ratio_valid_q <= 1'b1;
				mop_d_q       <= d_q;
				if (do_grow) begin
					mop_f_q <= grow_q;
					op_q    <= trru_pkg::OP_GROW;
				end else begin
					mop_f_q <= shrink_q;
					op_q    <= inp_q.took_full_step ? trru_pkg::OP_SHR_A : trru_pkg::OP_SHR_P;
				end
			end
			trru_pkg::ST_M_LO: mlo_q <= mul_p;
			trru_pkg::ST_M_HI: mhi_q <= mul_p;
			trru_pkg::ST_M_FIN: begin
				unique case (op_q)
					trru_pkg::OP_SHR_A: begin
						ta_q    <= mul_res;
						mop_d_q <= {1'b0, inp_q.full_step_norm};
						op_q    <= trru_pkg::OP_SHR_B;
					end
					trru_pkg::OP_SHR_B: begin
						tb_q  <= mul_res;
						cnt_q <= '0;
					end
					trru_pkg::OP_SHR_P: d_q <= mul_res;
					default: d_q <= res_gt_max ? {1'b0, rad_max_q} : mul_res;
				endcase
			end
			trru_pkg::ST_PROD: begin
				mp_q <= mul_p;
				if (cnt_q == '0) acc_q <= '0;
				else acc_q <= acc_q + pp_sh;
				if (cnt_q == 7'd4) begin
					cnt_q  <= '0;
					srem_q <= '0;
					root_q <= '0;
				end else begin
					cnt_q <= cnt_q + 7'd1;
				end
			end
			trru_pkg::ST_SQRT: begin
				acc_q  <= acc_q << 2;
				srem_q <= sq_ge ? sq_sh - sq_trial : sq_sh;
				root_q <= {root_q[62:0], sq_ge};
				cnt_q  <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) d_q <= {root_q[62:0], sq_ge};
			end
			trru_pkg::ST_CLAMP: begin
				if (d_q < {1'b0, rad_min_q}) begin
					d_q  <= {1'b0, rad_min_q};
					ok_q <= 1'b0;
				end
			end
			trru_pkg::ST_FIN: begin
				if (fin_go) begin
					out_q.new_radius   <= d_q[63] ? trru_pkg::MaxPos[62:0] : d_q[62:0];
					out_q.reject_step  <= !a_neg_q && (a_mag_q != '0);
					out_q.update_ok    <= ok_q;
					out_q.change_ratio <= ratio_q;
					out_q.ratio_valid  <= ratio_valid_q;
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== design/trru_checker.sv =====
`default_nettype none
module trru_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           in_valid,
	input wire logic           in_ready,
	input wire logic           out_valid,
	input wire logic           out_ready,
	input wire trru_pkg::out_t out_data
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("stalled result changed");

	// block is busy right after taking a transaction
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	// no ratio means a zero ratio field
	a_ratio_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.ratio_valid |-> out_data.change_ratio == '0)
		else $error("ratio set without valid");

endmodule

bind trust_region_radius_update_top trru_checker u_trru_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
	typedef trru_pkg::in_t in_t;
	typedef trru_pkg::out_t out_t;
	typedef trru_pkg::cfg_idx_t cfg_idx_t;
	localparam logic [63:0] SignBit = trru_pkg::SignBit;
	localparam logic [63:0] MaxPos  = trru_pkg::MaxPos;

	localparam int unsigned CycleLimit = 8000000;
	localparam int unsigned RandomItems = 1600;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [62:0] cfg_data = '0;

	trust_region_radius_update_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow copy of the block's registers and radius
	logic [31:0] good_lo, good_hi, grow_f, ok_lo, ok_hi, shrink_f;
	logic [62:0] rad_min, rad_max, radius_now;

	out_t radius_q[$];
	int unsigned mismatches = 0;
	int unsigned results_seen = 0;
	int unsigned items_sent = 0;
	int unsigned cycles = 0;
	bit hold_req = 1'b0;

	// Q8.24 multiply with the block's saturation rule
	function automatic logic [63:0] mul_q24(logic [63:0] d, logic [31:0] f);
		logic [63:0] hi;
		logic [95:0] p;
		hi = (d >> 32) * {32'b0, f};
		p = {32'b0, d} * {64'b0, f};
		if (hi[63:55] != 0)
			return '1;
		return p[87:24];
	endfunction

	function automatic logic [63:0] isqrt(logic [127:0] n);
		logic [63:0] r, c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'b0, c} * {64'b0, c} <= n)
				r = c;
		end
		return r;
	endfunction

	// next radius and status for one transaction; advances the shadow radius
	function automatic out_t next_radius(in_t x);
		logic signed [64:0] ad, pd;
		logic a_neg, p_neg, neg, ok, valid;
		logic [63:0] a_mag, p_mag, m, d, ta, tb, ratio;
		logic [111:0] q;
		logic gt_lg, lt_ug, lt_lo, gt_uo;
		out_t o;
		ad = {x.new_residual[63], x.new_residual} - {x.base_residual[63], x.base_residual};
		pd = {x.predicted_residual[63], x.predicted_residual}
			- {x.base_residual[63], x.base_residual};
		a_neg = ad[64];
		p_neg = pd[64];
		a_mag = a_neg ? 64'(-ad) : ad[63:0];
		p_mag = p_neg ? 64'(-pd) : pd[63:0];
		d = {1'b0, radius_now};
		ok = 1'b1;
		valid = 1'b0;
		ratio = '0;
		if (p_mag == 0) begin
			if (d >= {1'b0, rad_max}) begin
				ok = 1'b0;
			end else begin
				d = mul_q24(d, trru_pkg::ForcedGrowQ24);
				if (d > {1'b0, rad_max})
					d = {1'b0, rad_max};
			end
		end else begin
			q = {a_mag, 48'b0} / {48'b0, p_mag};
			m = (q > {48'b0, SignBit}) ? SignBit : q[63:0];
			neg = (a_neg != p_neg) && m != 0;
			if (!neg && m > MaxPos)
				m = MaxPos;
			ratio = neg ? -m : m;
			valid = 1'b1;
			gt_lg = !neg && m > ({32'b0, good_lo} << 24);
			lt_ug = neg || m < ({32'b0, good_hi} << 24);
			lt_lo = neg || m < ({32'b0, ok_lo} << 24);
			gt_uo = !neg && m > ({32'b0, ok_hi} << 24);
			if (gt_lg && a_neg && a_mag != 0 && lt_ug) begin
				if (!x.took_full_step) begin
					d = mul_q24(d, grow_f);
					if (d > {1'b0, rad_max})
						d = {1'b0, rad_max};
				end
			end else if (lt_lo || gt_uo) begin
				if (x.took_full_step) begin
					ta = mul_q24(d, shrink_f);
					tb = mul_q24({1'b0, x.full_step_norm}, shrink_f);
					d = isqrt({64'b0, ta} * {64'b0, tb});
				end else begin
					d = mul_q24(d, shrink_f);
				end
				if (d < {1'b0, rad_min}) begin
					d = {1'b0, rad_min};
					ok = 1'b0;
				end
			end
		end
		if (d > MaxPos)
			d = MaxPos;
		radius_now = d[62:0];
		o.new_radius = d[62:0];
		o.reject_step = !a_neg && a_mag != 0;
		o.update_ok = ok;
		o.change_ratio = ratio;
		o.ratio_valid = valid;
		return o;
	endfunction

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver: check each transaction, then pick next ready
	int unsigned stall_left = 0;
	bit hold_taken = 1'b0;
	always @(posedge clk) begin
		out_t want;
		if (out_valid && out_ready) begin
			results_seen++;
			if (radius_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result %p", out_data);
			end else begin
				want = radius_q.pop_front();
				if (out_data.new_radius !== want.new_radius
					|| out_data.reject_step !== want.reject_step
					|| out_data.update_ok !== want.update_ok
					|| out_data.change_ratio !== want.change_ratio
					|| out_data.ratio_valid !== want.ratio_valid) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("Result %0d: expected rad=%h rej=%b ok=%b ratio=%h rv=%b,",
							results_seen, want.new_radius, want.reject_step, want.update_ok,
							want.change_ratio, want.ratio_valid);
						$display(" got rad=%h rej=%b ok=%b ratio=%h rv=%b",
							out_data.new_radius, out_data.reject_step, out_data.update_ok,
							out_data.change_ratio, out_data.ratio_valid);
					end
				end
			end
		end
		if (hold_req && !hold_taken) begin
			hold_taken = 1'b1;
			stall_left = 3000;
		end else if (stall_left == 0 && $urandom_range(0, 99) == 0) begin
			stall_left = $urandom_range(20, 400);
		end
		if (stall_left != 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) < 70);
		end
	end

	// offer one transaction and hold it until accepted
	task automatic send(in_t x, bit typed, out_t typed_exp);
		out_t p;
		in_valid <= 1'b1;
		in_data <= x;
		do @(posedge clk); while (!in_ready);
		p = next_radius(x);
		radius_q.push_back(typed ? typed_exp : p);
		items_sent++;
	endtask

	// drop valid for a random gap
	task automatic idle_gap();
		int unsigned g, r;
		r = $urandom_range(0, 99);
		g = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 5) : $urandom_range(20, 300);
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (radius_q.size() != 0)
			@(posedge clk);
		repeat ($urandom_range(1, 10)) @(posedge clk);
	endtask

	// write one register; the caller drops the write enable after the last one
	task automatic write_reg(cfg_idx_t idx, logic [62:0] v);
		case (idx)
			trru_pkg::CFG_GOOD_LOW:  good_lo = v[31:0];
			trru_pkg::CFG_GOOD_HIGH: good_hi = v[31:0];
			trru_pkg::CFG_GROW:      grow_f = v[31:0];
			trru_pkg::CFG_OK_LOW:    ok_lo = v[31:0];
			trru_pkg::CFG_OK_HIGH:   ok_hi = v[31:0];
			trru_pkg::CFG_SHRINK:    shrink_f = v[31:0];
			trru_pkg::CFG_RAD_MIN:   rad_min = v;
			trru_pkg::CFG_RAD_MAX:   rad_max = v;
			default: ;
		endcase
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// mostly well-formed iterations around the thresholds, some noise
	function automatic in_t gen_item();
		in_t x;
		int unsigned k;
		logic [63:0] delta;
		logic [31:0] r;
		logic [127:0] act;
		x.new_residual = rand64();
		x.base_residual = rand64();
		x.predicted_residual = rand64();
		x.took_full_step = 1'($urandom_range(0, 1));
		x.full_step_norm = 63'(rand64() >> $urandom_range(0, 40));
		k = $urandom_range(0, 9);
		if (k == 0)
			return x;
		if (k == 1) begin
			x.predicted_residual = x.base_residual;
			return x;
		end
		x.base_residual = $signed(x.base_residual) >>> $urandom_range(0, 40);
		delta = rand64() >> $urandom_range(8, 60);
		case ($urandom_range(0, 6))
			0: r = good_lo + $urandom_range(0, 2) - 1;
			1: r = good_hi + $urandom_range(0, 2) - 1;
			2: r = ok_lo + $urandom_range(0, 2) - 1;
			3: r = ok_hi + $urandom_range(0, 2) - 1;
			4: r = $urandom_range(0, 32'h0800_0000);
			default: r = $urandom;
		endcase
		act = ({64'b0, delta} * {96'b0, r}) >> 24;
		x.predicted_residual = x.base_residual - delta;
		if ($urandom_range(0, 7) == 0)
			x.new_residual = x.base_residual + act[63:0];
		else
			x.new_residual = x.base_residual - act[63:0];
		return x;
	endfunction

	typedef struct {
		in_t item;
		bit typed;
		out_t want;
	} row_t;

	row_t rows[$];

	function automatic in_t mk(logic [63:0] nr, logic [63:0] br, logic [63:0] pr,
		logic fs, logic [62:0] nm);
		in_t x;
		x.new_residual = nr;
		x.base_residual = br;
		x.predicted_residual = pr;
		x.took_full_step = fs;
		x.full_step_norm = nm;
		return x;
	endfunction

	localparam logic [63:0] Q1 = 64'd1 << 48;

	initial begin
		out_t none, first;
		row_t rw;
		logic [62:0] v [8];
		none = '0;
		first = '0;
		first.new_radius = 63'(trru_pkg::ForcedGrowQ24) << 24;
		first.update_ok = 1'b1;

		// directed table; first row right after reset has a typed result
		rw = '{mk(0, 0, 0, 0, 0), 1'b1, first}; rows.push_back(rw);
		rw = '{mk(MaxPos, SignBit, SignBit + 1, 1, '1), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(SignBit, 0, 1, 0, 0), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(-64'd1, 0, MaxPos, 1, '1), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(SignBit, MaxPos, SignBit, 0, 0), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(90 * Q1, 100 * Q1, 90 * Q1, 0, Q1), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(90 * Q1, 100 * Q1, 90 * Q1, 1, Q1), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(99 * Q1, 100 * Q1, 90 * Q1, 0, Q1), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(99 * Q1, 100 * Q1, 90 * Q1, 1, 4 * Q1), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(110 * Q1, 100 * Q1, 90 * Q1, 1, '1), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(0, 100 * Q1, 99 * Q1, 0, 0), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(100 * Q1, 100 * Q1, 90 * Q1, 0, 0), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(5, 5, 5, 1, '1), 1'b0, none}; rows.push_back(rw);
		rw = '{mk(-64'd7, MaxPos, MaxPos, 0, 0), 1'b0, none}; rows.push_back(rw);
		for (int i = 0; i < 6; i++) begin
			rw = '{mk(0, Q1, 0, 1, 0), 1'b0, none};
			rows.push_back(rw);
		end
		for (int i = 0; i < 4; i++) begin
			rw = '{mk(SignBit, SignBit, 0, i[0], '0), 1'b0, none};
			rows.push_back(rw);
		end

		good_lo = 32'd12582912; good_hi = 32'd23488102; grow_f = 32'd25165824;
		ok_lo = 32'd5872026; ok_hi = 32'd83886080; shrink_f = 32'd4194304;
		rad_min = 63'd281; rad_max = 63'd2814749767106560000;
		radius_now = trru_pkg::RadiusOne;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table with reset settings
		foreach (rows[i]) begin
			send(rows[i].item, rows[i].typed, rows[i].want);
			idle_gap();
		end
		drain();

		// random phases, each with its own register setting
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: v = '{12582912, 23488102, 25165824, 5872026, 83886080, 4194304,
					281, 63'd2814749767106560000};
				1: v = '{0, 0, 0, 0, 0, 0, 0, 0};
				2: v = '{'1, '1, '1, '1, '1, '1, '1, '1};
				3: v = '{1 << 23, 1 << 25, 1 << 26, 1 << 22, 1 << 27, 1 << 20,
					1 << 40, 1 << 52};
				4: v = '{1 << 24, 3 << 23, 33554432, 1 << 23, 1 << 25, 15 << 20,
					1 << 49, 1 << 45};
				default:
					for (int j = 0; j < 8; j++)
						v[j] = 63'({$urandom, $urandom} >> $urandom_range(0, 30));
			endcase
			for (int j = 0; j < 8; j++)
				write_reg(cfg_idx_t'(j), v[j]);
			cfg_we <= 1'b0;
			for (int n = 0; n < RandomItems / 8; n++) begin
				if (ph == 2 && n == 10)
					hold_req = 1'b1;
				if (ph == 5 && n == 100)
					drain();
				send(gen_item(), 1'b0, none);
				idle_gap();
			end
			drain();
		end

		while (radius_q.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		$display("Covered %0d transactions over 9 register settings, %0d results checked",
			items_sent, results_seen);
		if (mismatches == 0 && radius_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
